FILE: design/fsgs_pkg.sv
// Shared types and constants for the falling-sand grid stepper.
// Holds the datapath operation codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package fsgs_pkg;

	localparam int AccW   = 24;
	localparam int IntW   = 20;
	localparam int ElW    = 20;
	localparam int CoordW = 5;
	localparam int IdxW   = 5;
	localparam int OutW   = 32;
	localparam int ApbW   = 32;
	localparam int AddrW  = 3;

	localparam logic [AccW-1:0] AccMax        = '1;
	localparam logic [IntW-1:0] IntervalReset = 20'd50000;

	// Register indexes on the configuration port.
	localparam logic REG_STEP_INTERVAL = 1'b0;

	// Operations that the controller asks of the datapath, one per cycle.
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_PLACE_RD = 4'd1;
	localparam logic [3:0] OP_PLACE_WR = 4'd2;
	localparam logic [3:0] OP_EMIT     = 4'd3;
	localparam logic [3:0] OP_G_RD0    = 4'd4;
	localparam logic [3:0] OP_G_RD1    = 4'd5;
	localparam logic [3:0] OP_G_LD     = 4'd6;
	localparam logic [3:0] OP_G_ROW    = 4'd7;
	localparam logic [3:0] OP_G_SHIFT  = 4'd8;
	localparam logic [3:0] OP_G_WRL    = 4'd9;
	localparam logic [3:0] OP_G_WRC    = 4'd10;

	typedef logic [3:0] dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   capture;
	} dp_cmd_t;

	typedef struct packed {
		logic step;
		logic emit_last;
		logic row_last;
		logic col_last;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: design/fsgs_ctrl.sv
// Sequencing state machine of the falling-sand grid stepper.
// Issues one datapath operation per cycle; depends on fsgs_pkg.
`default_nettype none

module fsgs_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               accept,
	input  wire               kind,
	input  fsgs_pkg::dp_stat_t stat,
	output fsgs_pkg::dp_cmd_t  cmd,
	output logic              busy
);
	import fsgs_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_PLACE_RD = 4'd1;
	localparam logic [3:0] S_PLACE_WR = 4'd2;
	localparam logic [3:0] S_EMIT     = 4'd3;
	localparam logic [3:0] S_G_RD0    = 4'd4;
	localparam logic [3:0] S_G_RD1    = 4'd5;
	localparam logic [3:0] S_G_LD     = 4'd6;
	localparam logic [3:0] S_G_ROW    = 4'd7;
	localparam logic [3:0] S_G_SHIFT  = 4'd8;
	localparam logic [3:0] S_G_WRL    = 4'd9;
	localparam logic [3:0] S_G_WRC    = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx    = state_q;
		cmd.op      = OP_NONE;
		cmd.capture = accept;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nx = kind ? S_EMIT : S_PLACE_RD;
				end
			end
			S_PLACE_RD: begin
				cmd.op   = OP_PLACE_RD;
				state_nx = S_PLACE_WR;
			end
			S_PLACE_WR: begin
				cmd.op   = OP_PLACE_WR;
				state_nx = S_IDLE;
			end
			S_EMIT: begin
				cmd.op = OP_EMIT;
				if (stat.emit_last) begin
					state_nx = stat.step ? S_G_RD0 : S_IDLE;
				end
			end
			S_G_RD0: begin
				cmd.op   = OP_G_RD0;
				state_nx = S_G_RD1;
			end
			S_G_RD1: begin
				cmd.op   = OP_G_RD1;
				state_nx = S_G_LD;
			end
			S_G_LD: begin
				cmd.op   = OP_G_LD;
				state_nx = S_G_ROW;
			end
			S_G_ROW: begin
				cmd.op = OP_G_ROW;
				if (stat.row_last) begin
					state_nx = stat.col_last ? S_G_WRL : S_G_SHIFT;
				end
			end
			S_G_SHIFT: begin
				cmd.op   = OP_G_SHIFT;
				state_nx = S_G_LD;
			end
			S_G_WRL: begin
				cmd.op   = OP_G_WRL;
				state_nx = S_G_WRC;
			end
			S_G_WRC: begin
				cmd.op   = OP_G_WRC;
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: design/fsgs_dp.sv
// Datapath of the falling-sand grid stepper: column memory, sliding column window,
// time accumulator and result registers. Depends on fsgs_pkg.
`default_nettype none

module fsgs_dp #(
	parameter int GRID_WIDTH  = 32,
	parameter int GRID_HEIGHT = 32
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  fsgs_pkg::dp_cmd_t                 cmd,
	input  wire                               kind,
	input  wire  [fsgs_pkg::CoordW-1:0]       cell_x,
	input  wire  [fsgs_pkg::CoordW-1:0]       cell_y,
	input  wire  [fsgs_pkg::ElW-1:0]          elapsed_us,
	input  wire                               prefer_right,
	input  wire  [fsgs_pkg::IntW-1:0]         interval,
	output fsgs_pkg::dp_stat_t                stat,
	output logic                              strobe,
	output logic [fsgs_pkg::IdxW-1:0]         column_index,
	output logic [fsgs_pkg::OutW-1:0]         column_bits,
	output logic                              stepped,
	output logic                              last
);
	import fsgs_pkg::*;

	localparam int CW    = $clog2(GRID_WIDTH);
	localparam int RW    = $clog2(GRID_HEIGHT);
	localparam int NEmit = (GRID_WIDTH < OutW) ? GRID_WIDTH : OutW;
	localparam int ExtW  = (GRID_HEIGHT > OutW) ? GRID_HEIGHT : OutW;

	// Column memory; a column never written since reset reads as empty.
	logic [GRID_HEIGHT-1:0] mem [GRID_WIDTH];
	logic [GRID_WIDTH-1:0]  valid_q;
	logic [GRID_HEIGHT-1:0] rd_q;
	logic                   rv_q;
	logic [GRID_HEIGHT-1:0] rdata;

	logic                   re;
	logic                   we;
	logic [CW-1:0]          raddr;
	logic [CW-1:0]          waddr;
	logic [GRID_HEIGHT-1:0] wdata;

	// Window over columns x-1, x, x+1 plus the pre-generation copies of x and x+1.
	logic [GRID_HEIGHT-1:0] left_q, cur_q, right_q, snap_q, nsnap_q;
	logic [GRID_HEIGHT-1:0] left_nx, cur_nx, right_nx;
	logic [CW-1:0]          col_q;
	logic [RW-1:0]          row_q;
	logic [RW-1:0]          row_n;
	logic [CW:0]            col_p2;
	logic                   col_p2_ok;

	logic [CW-1:0]          px_q;
	logic [RW-1:0]          py_q;
	logic                   place_ok_q;
	logic                   prefer_q;

	logic [AccW-1:0]        acc_q;
	logic                   step_q;
	logic [AccW:0]          acc_sum;
	logic [AccW-1:0]        acc_sat;
	logic                   acc_step;

	logic                   strobe_q;
	logic [IdxW-1:0]        idx_s1;
	logic                   last_s1;
	logic [ExtW-1:0]        col_ext;

	logic sy, sb, can_r, can_l, go_r, go_l;

	assign rdata     = rv_q ? rd_q : '0;
	assign col_p2    = {1'b0, col_q} + (CW+1)'(2);
	assign col_p2_ok = (col_p2 < (CW+1)'(GRID_WIDTH));
	assign row_n     = row_q + RW'(1);

	assign stat.step      = step_q;
	assign stat.emit_last = (col_q == CW'(NEmit - 1));
	assign stat.col_last  = (col_q == CW'(GRID_WIDTH - 1));
	assign stat.row_last  = (row_q == RW'(GRID_HEIGHT - 2));

	// Memory port selection per operation.
	always_comb begin
		re    = 1'b0;
		we    = 1'b0;
		raddr = col_q;
		waddr = col_q;
		wdata = cur_q;
		case (cmd.op)
			OP_PLACE_RD: begin
				re    = 1'b1;
				raddr = px_q;
			end
			OP_PLACE_WR: begin
				we    = place_ok_q;
				waddr = px_q;
				wdata = rdata | (GRID_HEIGHT'(1) << py_q);
			end
			OP_EMIT: begin
				re = 1'b1;
			end
			OP_G_RD0: begin
				re    = 1'b1;
				raddr = '0;
			end
			OP_G_RD1: begin
				re    = 1'b1;
				raddr = CW'(1);
			end
			OP_G_SHIFT: begin
				we    = (col_q != '0);
				waddr = col_q - CW'(1);
				wdata = left_q;
				re    = col_p2_ok;
				raddr = col_p2[CW-1:0];
			end
			OP_G_WRL: begin
				we    = 1'b1;
				waddr = col_q - CW'(1);
				wdata = left_q;
			end
			OP_G_WRC: begin
				we = 1'b1;
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
			rv_q <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// One row of the current column: decisions come from the snapshot, targets
	// on the sides come from the live window.
	always_comb begin
		left_nx  = left_q;
		cur_nx   = cur_q;
		right_nx = right_q;
		sy       = snap_q[row_q];
		sb       = snap_q[row_n];
		can_r    = !stat.col_last && !right_q[row_n];
		can_l    = (col_q != '0) && !left_q[row_n];
		go_r     = can_r && (prefer_q || !can_l);
		go_l     = can_l && !go_r;
		if (sy) begin
			if (!sb) begin
				cur_nx[row_q] = 1'b0;
				cur_nx[row_n] = 1'b1;
			end else if (go_r) begin
				cur_nx[row_q]   = 1'b0;
				right_nx[row_n] = 1'b1;
			end else if (go_l) begin
				cur_nx[row_q]  = 1'b0;
				left_nx[row_n] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			col_q      <= '0;
			px_q       <= CW'(cell_x);
			py_q       <= RW'(cell_y);
			place_ok_q <= (32'(cell_x) < 32'(GRID_WIDTH)) && (32'(cell_y) < 32'(GRID_HEIGHT));
			prefer_q   <= prefer_right;
		end
		case (cmd.op)
			OP_EMIT: begin
				col_q <= col_q + CW'(1);
			end
			OP_G_RD0: begin
				col_q <= '0;
			end
			OP_G_RD1: begin
				cur_q  <= rdata;
				snap_q <= rdata;
			end
			OP_G_LD: begin
				right_q <= rdata;
				nsnap_q <= rdata;
				row_q   <= '0;
			end
			OP_G_ROW: begin
				left_q  <= left_nx;
				cur_q   <= cur_nx;
				right_q <= right_nx;
				row_q   <= row_n;
			end
			OP_G_SHIFT: begin
				left_q <= cur_q;
				cur_q  <= right_q;
				snap_q <= nsnap_q;
				col_q  <= col_q + CW'(1);
			end
			default: begin
				row_q <= row_q;
			end
		endcase
	end

	// Saturating time accumulator, updated when a frame is taken.
	assign acc_sum  = {1'b0, acc_q} + (AccW+1)'(elapsed_us);
	assign acc_sat  = acc_sum[AccW] ? AccMax : acc_sum[AccW-1:0];
	assign acc_step = (acc_sat > AccW'(interval));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			step_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (cmd.capture && kind) begin
				step_q <= acc_step;
				acc_q  <= acc_step ? '0 : acc_sat;
			end
			strobe_q <= (cmd.op == OP_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			idx_s1  <= IdxW'(col_q);
			last_s1 <= stat.emit_last;
		end
	end

	assign col_ext      = ExtW'(rdata);
	assign strobe       = strobe_q;
	assign column_index = idx_s1;
	assign column_bits  = col_ext[OutW-1:0];
	assign stepped      = step_q;
	assign last         = last_s1;

endmodule

`default_nettype wire

FILE: design/falling_sand_grid_step.sv
// Top level of the falling-sand grid stepper: command channel, configuration port,
// controller and datapath. Depends on fsgs_pkg, fsgs_ctrl and fsgs_dp.
//
// Usage: an item is transferred at a rising edge where start is high and busy is low.
// A place item (kind 0) sets one cell; busy stays high while the column is read and
// written back, and no result is produced. Places outside the grid are dropped. A
// frame item (kind 1) produces min(GRID_WIDTH, 32) results, one column per cycle on
// consecutive cycles, each marked by strobe for exactly one cycle; the first result
// comes after the controller enters its emit state and the column read and strobe
// registers load, and last marks the final column. The receiver cannot stall this
// stream. When the accumulated time exceeds step_interval_us, a generation follows
// the output. It walks the columns through a three-column register window backed by
// the column memory, one row per cycle.
// Reset empties the grid at once through per-column valid flags, clears the
// accumulator and loads step_interval_us with 50000. The APB port holds that
// register at address 0; writes are meant only while busy is low.
`default_nettype none

module falling_sand_grid_step #(
	parameter int GRID_WIDTH  = 32,
	parameter int GRID_HEIGHT = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire                          kind,
	input  wire  [fsgs_pkg::CoordW-1:0]  cell_x,
	input  wire  [fsgs_pkg::CoordW-1:0]  cell_y,
	input  wire  [fsgs_pkg::ElW-1:0]     elapsed_us,
	input  wire                          prefer_right,
	output logic                         strobe,
	output logic [fsgs_pkg::IdxW-1:0]    column_index,
	output logic [fsgs_pkg::OutW-1:0]    column_bits,
	output logic                         stepped,
	output logic                         last,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [fsgs_pkg::AddrW-1:0]   paddr,
	input  wire  [fsgs_pkg::ApbW-1:0]    pwdata,
	output logic [fsgs_pkg::ApbW-1:0]    prdata,
	output logic                         pready
);
	import fsgs_pkg::*;

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic             accept;
	logic [IntW-1:0]  interval_q;
	logic             reg_sel;

	// An item transfer happens only while the sequencer is idle.
	assign accept = start && !busy;

	// The register index sits in the word-address bit; other indexes are ignored.
	assign reg_sel = (paddr[AddrW-1] == REG_STEP_INTERVAL);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? ApbW'(interval_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= IntervalReset;
		end else if (psel && penable && pwrite && reg_sel) begin
			interval_q <= pwdata[IntW-1:0];
		end
	end

	fsgs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	fsgs_dp #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.kind         (kind),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.elapsed_us   (elapsed_us),
		.prefer_right (prefer_right),
		.interval     (interval_q),
		.stat         (stat),
		.strobe       (strobe),
		.column_index (column_index),
		.column_bits  (column_bits),
		.stepped      (stepped),
		.last         (last)
	);

`ifndef ASSERT_OFF
	// Every accepted item makes the sequencer busy in the cycle after it is taken.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("busy not raised after an item transfer");

	// Columns of one frame come out back to back until the final one.
	a_stream_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe) else $error("gap inside a frame's column stream");

	// The stream of a frame stops right after its final column.
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe) else $error("result right after the final column");

	// A result is only produced while a frame is being processed.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("result outside a frame");
`endif

endmodule

`default_nettype wire
